@@ hdl/efr_pkg.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Byte codes, result kinds and widths shared by the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned KindW = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [KindW-1:0] kind_t;

  localparam byte_t StartByte  = 8'h7E;
  localparam byte_t EscapeByte = 8'h7D;
  localparam byte_t EscapeXor  = 8'h20;
  localparam byte_t SumBase    = 8'hFF;

  localparam kind_t KindData = 2'd0;
  localparam kind_t KindEnd  = 2'd1;
  localparam kind_t KindOob  = 2'd2;

endpackage

`default_nettype wire

@@ hdl/escaped_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Deframes start-delimited, length-prefixed, byte-escaped frames with an
// 8-bit sum check, one received byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Each byte's result passes through the input register and then the result
// register on its way to the outputs.
// Throughput: one byte per cycle unless out_stall_i holds the result slot,
// set by the single decode step between the input and result registers.
// Bytes that give no result (start, escape, length) only update frame state.
// Reset clears the frame state to idle and empties both registers.
`default_nettype none

module escaped_frame_receiver (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire efr_pkg::byte_t rx_byte_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output efr_pkg::kind_t      kind_o,
  output efr_pkg::byte_t      value_o,
  output logic                last_o,
  output logic                checksum_ok_o,
  output efr_pkg::len_t       frame_length_o
);
  import efr_pkg::*;

  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhLenHi    = 3'd1;
  localparam logic [2:0] PhLenLo    = 3'd2;
  localparam logic [2:0] PhPayload  = 3'd3;
  localparam logic [2:0] PhChecksum = 3'd4;

  logic       in_v_q;
  byte_t      in_byte_q;
  logic       advance;
  logic       work;

  logic [2:0] phase_q, phase_d;
  logic       esc_q, esc_d;
  len_t       len_q, len_d;
  len_t       left_q, left_d;
  byte_t      sum_q, sum_d;

  logic       res_v;
  kind_t      res_kind;
  byte_t      res_value;
  logic       res_last;
  logic       res_ok;
  len_t       res_len;
  byte_t      data_b;
  logic       proceed;
  len_t       left_dec;

  logic       out_v_q;
  kind_t      kind_q;
  byte_t      value_q;
  logic       last_q;
  logic       ok_q;
  len_t       len_out_q;

  // The request in the input register moves on whenever the result slot
  // is free or being taken in this cycle.
  assign advance    = !out_v_q || !out_stall_i;
  assign work       = in_v_q && advance;
  assign in_stall_o = in_v_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  assign left_dec = left_q - len_t'(1);

  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    len_d     = len_q;
    left_d    = left_q;
    sum_d     = sum_q;
    res_v     = 1'b0;
    res_kind  = KindData;
    res_value = '0;
    res_last  = 1'b0;
    res_ok    = 1'b0;
    res_len   = '0;
    data_b    = in_byte_q;
    proceed   = 1'b0;

    if (phase_q == PhLenHi || phase_q == PhLenLo || phase_q == PhPayload ||
        phase_q == PhChecksum) begin
      if (esc_q) begin
        esc_d   = 1'b0;
        data_b  = in_byte_q ^ EscapeXor;
        proceed = 1'b1;
      end else if (in_byte_q == EscapeByte) begin
        esc_d = 1'b1;
      end else begin
        proceed = 1'b1;
      end
    end

    unique case (phase_q)
      PhLenHi: begin
        if (proceed) begin
          len_d   = {data_b, len_q[ByteW-1:0]};
          phase_d = PhLenLo;
        end
      end
      PhLenLo: begin
        if (proceed) begin
          len_d   = {len_q[LenW-1:ByteW], data_b};
          left_d  = {len_q[LenW-1:ByteW], data_b};
          phase_d = ({len_q[LenW-1:ByteW], data_b} == '0) ? PhChecksum : PhPayload;
        end
      end
      PhPayload: begin
        if (proceed) begin
          sum_d     = sum_q + data_b;
          left_d    = left_dec;
          phase_d   = (left_dec == '0) ? PhChecksum : PhPayload;
          res_v     = 1'b1;
          res_kind  = KindData;
          res_value = data_b;
        end
      end
      PhChecksum: begin
        if (proceed) begin
          res_v    = 1'b1;
          res_kind = KindEnd;
          res_last = 1'b1;
          res_ok   = ((SumBase - sum_q) == data_b);
          res_len  = len_q;
          phase_d  = PhIdle;
        end
      end
      default: begin
        esc_d = 1'b0;
        if (in_byte_q == StartByte) begin
          sum_d   = '0;
          len_d   = '0;
          left_d  = '0;
          phase_d = PhLenHi;
        end else begin
          phase_d   = PhIdle;
          res_v     = 1'b1;
          res_kind  = KindOob;
          res_value = in_byte_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      esc_q   <= 1'b0;
      len_q   <= '0;
      left_q  <= '0;
      sum_q   <= '0;
    end else if (work) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      len_q   <= len_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= work && res_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work && res_v) begin
      kind_q    <= res_kind;
      value_q   <= res_value;
      last_q    <= res_last;
      ok_q      <= res_ok;
      len_out_q <= res_len;
    end
  end

  assign out_valid_o    = out_v_q;
  assign kind_o         = kind_q;
  assign value_o        = value_q;
  assign last_o         = last_q;
  assign checksum_ok_o  = ok_q;
  assign frame_length_o = len_out_q;

  // A payload phase always has at least one byte still to come.
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> left_q != '0)
    else $error("payload phase with no bytes left");

  // The last flag marks exactly the frame end results.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (last_q == (kind_q == KindEnd)))
    else $error("last flag does not match result kind");

  // A frame end follows only from the checksum phase.
  a_end_from_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && res_v && res_kind == KindEnd) |-> phase_q == PhChecksum)
    else $error("frame end outside checksum phase");

  // An escape flag is never held while idle.
  a_idle_no_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && phase_d == PhIdle) |=> !esc_q)
    else $error("escape pending while idle");

endmodule

`default_nettype wire
